@@ rtl/core/gsbc_pkg.sv @@
// Shared types, constants and tables for the Gaussian sample band counter.
package gsbc_pkg;

  // Width of the uniform codes that are used, and of the band counters.
  localparam int UNIFORM_BITS = 32;
  localparam int COUNT_BITS   = 32;

  // Mask that keeps the used low bits of a uniform code.
  localparam logic [31:0] UNIFORM_MASK = 32'((64'd1 << UNIFORM_BITS) - 64'd1);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MEAN_IDX   = 2'd0,
    CFG_SPREAD_IDX = 2'd1
  } gsbc_cfg_idx_t;

  // Fixed-point constants in Q.30.
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Number of series terms: eight for sine, then eight for cosine.
  localparam int SERIES_TERMS = 16;

  // Series divisors (k-1)*k; sine terms first, then cosine terms.
  localparam logic [8:0] DIV_TAB [SERIES_TERMS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272,
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240
  };

  // Reciprocals floor((2^33 - 1) / d) for the divide by multiply.
  localparam logic [63:0] RECIP_NUM = (64'd1 << 33) - 64'd1;
  localparam logic [31:0] RECIP_TAB [SERIES_TERMS] = '{
    32'(RECIP_NUM / 64'd6),   32'(RECIP_NUM / 64'd20),  32'(RECIP_NUM / 64'd42),
    32'(RECIP_NUM / 64'd72),  32'(RECIP_NUM / 64'd110), 32'(RECIP_NUM / 64'd156),
    32'(RECIP_NUM / 64'd210), 32'(RECIP_NUM / 64'd272),
    32'(RECIP_NUM / 64'd2),   32'(RECIP_NUM / 64'd12),  32'(RECIP_NUM / 64'd30),
    32'(RECIP_NUM / 64'd56),  32'(RECIP_NUM / 64'd90),  32'(RECIP_NUM / 64'd132),
    32'(RECIP_NUM / 64'd182), 32'(RECIP_NUM / 64'd240)
  };

  // Input transaction.
  typedef struct packed {
    logic [31:0] uniform_radius;
    logic [31:0] uniform_angle;
    logic        keep_second;
    logic        clear_counts;
  } gsbc_in_t;

  // Result transaction.
  typedef struct packed {
    logic signed [31:0] sample_first;
    logic signed [31:0] sample_second;
    logic               second_valid;
    logic [31:0]        within_one_total;
    logic [31:0]        within_two_total;
    logic [31:0]        within_three_total;
  } gsbc_out_t;

  // Classified item as it waits in the queue.
  typedef struct packed {
    logic [31:0] radius_code;
    logic [1:0]  quadrant;
    logic [29:0] angle_frac;
    logic        keep_second;
    logic        clear_counts;
  } gsbc_entry_t;

  // Back-end sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_NORM,
    S_LOG_MUL,
    S_LOG_UPD,
    S_LN_A,
    S_LN_B,
    S_LN_C,
    S_TH_A,
    S_TH_B,
    S_TH_C,
    S_T_MUL,
    S_T_DIV,
    S_T_Q,
    S_T_FIX,
    S_SM_A,
    S_SM_B,
    S_SM_C,
    S_SM_D,
    S_OUT
  } gsbc_state_t;

endpackage

@@ rtl/core/gsbc_front.sv @@
// Front end: accepts input transactions and classifies them for the queue.
module gsbc_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gsbc_pkg::gsbc_in_t    in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output gsbc_pkg::gsbc_entry_t q_data
);

  logic [31:0] radius_masked;
  logic [31:0] phase;

  // Take a transaction whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  // A radius code of zero is used as one, so the logarithm stays finite.
  assign radius_masked = in_data.uniform_radius & gsbc_pkg::UNIFORM_MASK;

  // The angle code becomes a phase of a full turn, split into quadrant and fraction.
  assign phase = 32'((in_data.uniform_angle & gsbc_pkg::UNIFORM_MASK)
                     << (32 - gsbc_pkg::UNIFORM_BITS));

  always_comb begin
    q_data.radius_code  = (radius_masked == 32'd0) ? 32'd1 : radius_masked;
    q_data.quadrant     = phase[31:30];
    q_data.angle_frac   = phase[29:0];
    q_data.keep_second  = in_data.keep_second;
    q_data.clear_counts = in_data.clear_counts;
  end

endmodule

@@ rtl/core/gsbc_queue.sv @@
// Short queue of classified items between front end and back end.
module gsbc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  gsbc_pkg::gsbc_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  nonempty,
  output gsbc_pkg::gsbc_entry_t pop_data
);

  gsbc_pkg::gsbc_entry_t             mem_r [gsbc_pkg::QUEUE_DEPTH];
  logic [gsbc_pkg::QPTR_BITS-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [gsbc_pkg::QPTR_BITS-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [gsbc_pkg::QCNT_BITS-1:0]    count_r, count_nxt;
  logic                              do_push, do_pop;

  assign full     = (count_r == gsbc_pkg::QCNT_BITS'(gsbc_pkg::QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & nonempty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == gsbc_pkg::QPTR_BITS'(gsbc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == gsbc_pkg::QPTR_BITS'(gsbc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/gsbc_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module gsbc_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] src,
  output logic        busy,
  output logic [30:0] root
);

  logic [61:0] src_r, src_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [30:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign busy = (cnt_r != 5'd0);
  assign root = root_r;

  // One step: bring down two bits and try the next root bit.
  always_comb begin
    src_nxt  = src_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    rem_sh   = {rem_r, src_r[61:60]};
    trial    = {3'b000, root_r, 2'b01};
    if (start) begin
      src_nxt  = src;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd31;
    end else if (busy) begin
      if (rem_sh >= trial) begin
        rem_nxt  = 34'(rem_sh - trial);
        root_nxt = {root_r[29:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[33:0];
        root_nxt = {root_r[29:0], 1'b0};
      end
      src_nxt = {src_r[59:0], 2'b00};
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

endmodule

@@ rtl/core/gsbc_back.sv @@
// Back end: sequencer with a shared multiplier that computes the samples and counts.
module gsbc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_nonempty,
  input  gsbc_pkg::gsbc_entry_t  q_data,
  output logic                   q_pop,
  input  logic signed [31:0]     mean_value,
  input  logic [30:0]            spread_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gsbc_pkg::gsbc_out_t    out_data
);

  localparam int CB = gsbc_pkg::COUNT_BITS;

  gsbc_pkg::gsbc_state_t state_r, state_nxt;

  logic [4:0]   cnt_r, cnt_nxt;
  logic [3:0]   step_r, step_nxt;
  logic         branch_r, branch_nxt;
  logic [31:0]  m_r, m_nxt;
  logic [4:0]   lz_r, lz_nxt;
  logic [29:0]  frac_r, frac_nxt;
  logic [30:0]  lnlo_r, lnlo_nxt;
  logic [30:0]  theta_r, theta_nxt;
  logic [31:0]  x2_r, x2_nxt;
  logic [31:0]  term_r, term_nxt;
  logic [31:0]  x_r, x_nxt;
  logic [30:0]  q0_r, q0_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic [30:0]  sin_r, sin_nxt;
  logic [30:0]  cos_r, cos_nxt;
  logic [1:0]   quad_r, quad_nxt;
  logic [29:0]  afrac_r, afrac_nxt;
  logic         keep_r, keep_nxt;
  logic         clear_r, clear_nxt;
  logic [31:0]  first_r, first_nxt;
  logic [31:0]  second_r, second_nxt;
  logic [CB-1:0] band1_r, band1_nxt;
  logic [CB-1:0] band2_r, band2_nxt;
  logic [CB-1:0] band3_r, band3_nxt;
  logic         out_valid_r, out_valid_nxt;
  gsbc_pkg::gsbc_out_t out_data_r, out_data_nxt;
  logic [63:0]  prod_r;

  logic [31:0]  mul_a, mul_b;
  logic         sq_start;
  logic [61:0]  sq_src;
  logic         sq_busy;
  logic [30:0]  sq_root;

  // Combinational helpers.
  logic [6:0]   log_int;
  logic [35:0]  t_val;
  logic [32:0]  log_p;
  logic [35:0]  s_val;
  logic [39:0]  qd;
  logic [39:0]  div_rem;
  logic [31:0]  q_fix;
  logic signed [33:0] acc_new;
  logic [30:0]  acc_clamp;
  logic [30:0]  trig_mag;
  logic         trig_neg;
  logic signed [34:0] mean35, mag35, v35;
  logic [31:0]  sample_sat;
  logic [31:0]  tally_smp;
  logic signed [32:0] diff33;
  logic [32:0]  abs_dist;
  logic [32:0]  sp1, sp2, sp3;
  logic [CB-1:0] base1, base2, base3;

  // Square root runs beside the trig series.
  gsbc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .src   (sq_src),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Integer part of -log2 and the Q.30 value t = int - fraction.
  assign log_int = 7'(gsbc_pkg::UNIFORM_BITS) - 7'd31 + {2'b00, lz_r};
  assign t_val   = {log_int[5:0], 30'd0} - {6'd0, frac_r};
  assign log_p   = prod_r[63:31];
  assign s_val   = prod_r[35:0] + {5'd0, lnlo_r};

  // Series term divide: fix the reciprocal estimate by one compare.
  assign qd      = {9'd0, q0_r} * {31'd0, gsbc_pkg::DIV_TAB[step_r]};
  assign div_rem = {8'd0, x_r} - qd;
  assign q_fix   = {1'b0, q0_r} + ((div_rem >= {31'd0, gsbc_pkg::DIV_TAB[step_r]}) ?
                                   32'd1 : 32'd0);
  assign acc_new = step_r[0] ? (acc_r + signed'({2'b00, q_fix}))
                             : (acc_r - signed'({2'b00, q_fix}));
  always_comb begin
    if (acc_new < 34'sd0) begin
      acc_clamp = 31'd0;
    end else if (acc_new > signed'({3'b000, gsbc_pkg::ONE_Q30})) begin
      acc_clamp = gsbc_pkg::ONE_Q30;
    end else begin
      acc_clamp = acc_new[30:0];
    end
  end

  // Quadrant symmetry selects magnitude and sign of cos (first) or sin (second).
  always_comb begin
    if (!branch_r) begin
      trig_mag = quad_r[0] ? sin_r : cos_r;
      trig_neg = (quad_r == 2'd1) || (quad_r == 2'd2);
    end else begin
      trig_mag = quad_r[0] ? cos_r : sin_r;
      trig_neg = quad_r[1];
    end
  end

  // Shift by the mean and saturate to the signed 32-bit range.
  assign mean35 = {{3{mean_value[31]}}, mean_value};
  assign mag35  = signed'({1'b0, prod_r[61:28]});
  assign v35    = trig_neg ? (mean35 - mag35) : (mean35 + mag35);
  always_comb begin
    if (v35 > 35'sd2147483647) begin
      sample_sat = 32'h7FFF_FFFF;
    end else if (v35 < -35'sd2147483648) begin
      sample_sat = 32'h8000_0000;
    end else begin
      sample_sat = v35[31:0];
    end
  end

  // Sample currently being tallied.
  assign tally_smp = branch_r ? second_r : first_r;

  // Band test on the distance from the mean.
  assign diff33   = signed'({tally_smp[31], tally_smp}) -
                    signed'({mean_value[31], mean_value});
  assign abs_dist = (diff33 < 33'sd0) ? 33'(-diff33) : 33'(diff33);
  assign sp1      = {2'b00, spread_value};
  assign sp2      = {1'b0, spread_value, 1'b0};
  assign sp3      = sp1 + sp2;
  assign base1    = (!branch_r && clear_r) ? '0 : band1_r;
  assign base2    = (!branch_r && clear_r) ? '0 : band2_r;
  assign base3    = (!branch_r && clear_r) ? '0 : band3_r;

  // Sequencer: next state, multiplier operands and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    branch_nxt    = branch_r;
    m_nxt         = m_r;
    lz_nxt        = lz_r;
    frac_nxt      = frac_r;
    lnlo_nxt      = lnlo_r;
    theta_nxt     = theta_r;
    x2_nxt        = x2_r;
    term_nxt      = term_r;
    x_nxt         = x_r;
    q0_nxt        = q0_r;
    acc_nxt       = acc_r;
    sin_nxt       = sin_r;
    cos_nxt       = cos_r;
    quad_nxt      = quad_r;
    afrac_nxt     = afrac_r;
    keep_nxt      = keep_r;
    clear_nxt     = clear_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    band1_nxt     = band1_r;
    band2_nxt     = band2_r;
    band3_nxt     = band3_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    mul_a         = 32'd0;
    mul_b         = 32'd0;
    q_pop         = 1'b0;
    sq_start      = 1'b0;
    sq_src        = {s_val, 26'd0};

    unique case (state_r)
      gsbc_pkg::S_IDLE: begin
        if (q_nonempty) begin
          q_pop      = 1'b1;
          m_nxt      = q_data.radius_code;
          lz_nxt     = 5'd0;
          quad_nxt   = q_data.quadrant;
          afrac_nxt  = q_data.angle_frac;
          keep_nxt   = q_data.keep_second;
          clear_nxt  = q_data.clear_counts;
          second_nxt = 32'd0;
          cnt_nxt    = 5'd0;
          state_nxt  = gsbc_pkg::S_NORM;
        end
      end

      // Normalize the radius code to Q1.31 in five binary steps.
      gsbc_pkg::S_NORM: begin
        case (cnt_r)
          5'd0: if (m_r[31:16] == 16'd0) begin
            m_nxt = {m_r[15:0], 16'd0};
            lz_nxt = lz_r + 5'd16;
          end
          5'd1: if (m_r[31:24] == 8'd0) begin
            m_nxt = {m_r[23:0], 8'd0};
            lz_nxt = lz_r + 5'd8;
          end
          5'd2: if (m_r[31:28] == 4'd0) begin
            m_nxt = {m_r[27:0], 4'd0};
            lz_nxt = lz_r + 5'd4;
          end
          5'd3: if (m_r[31:30] == 2'd0) begin
            m_nxt = {m_r[29:0], 2'd0};
            lz_nxt = lz_r + 5'd2;
          end
          default: if (!m_r[31]) begin
            m_nxt = {m_r[30:0], 1'b0};
            lz_nxt = lz_r + 5'd1;
          end
        endcase
        if (cnt_r == 5'd4) begin
          cnt_nxt   = 5'd0;
          frac_nxt  = 30'd0;
          state_nxt = gsbc_pkg::S_LOG_MUL;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end

      // Log2 fraction by repeated squaring: square, then take one bit in the update.
      gsbc_pkg::S_LOG_MUL: begin
        mul_a     = m_r;
        mul_b     = m_r;
        state_nxt = gsbc_pkg::S_LOG_UPD;
      end

      gsbc_pkg::S_LOG_UPD: begin
        m_nxt    = log_p[32] ? log_p[32:1] : log_p[31:0];
        frac_nxt = {frac_r[28:0], log_p[32]};
        if (cnt_r == 5'd29) begin
          state_nxt = gsbc_pkg::S_LN_A;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = gsbc_pkg::S_LOG_MUL;
        end
      end

      // Scale by 2 ln 2: fraction part, then integer part.
      gsbc_pkg::S_LN_A: begin
        mul_a     = {2'b00, t_val[29:0]};
        mul_b     = {1'b0, gsbc_pkg::TWO_LN2_Q30};
        state_nxt = gsbc_pkg::S_LN_B;
      end

      gsbc_pkg::S_LN_B: begin
        lnlo_nxt  = prod_r[60:30];
        mul_a     = {26'd0, t_val[35:30]};
        mul_b     = {1'b0, gsbc_pkg::TWO_LN2_Q30};
        state_nxt = gsbc_pkg::S_LN_C;
      end

      gsbc_pkg::S_LN_C: begin
        sq_start  = 1'b1;
        state_nxt = gsbc_pkg::S_TH_A;
      end

      // Angle in radians and its square.
      gsbc_pkg::S_TH_A: begin
        mul_a     = {2'b00, afrac_r};
        mul_b     = {1'b0, gsbc_pkg::HALF_PI_Q30};
        state_nxt = gsbc_pkg::S_TH_B;
      end

      gsbc_pkg::S_TH_B: begin
        theta_nxt = prod_r[60:30];
        mul_a     = {1'b0, prod_r[60:30]};
        mul_b     = {1'b0, prod_r[60:30]};
        state_nxt = gsbc_pkg::S_TH_C;
      end

      gsbc_pkg::S_TH_C: begin
        x2_nxt    = prod_r[61:30];
        term_nxt  = {1'b0, theta_r};
        acc_nxt   = signed'({3'b000, theta_r});
        step_nxt  = 4'd0;
        state_nxt = gsbc_pkg::S_T_MUL;
      end

      // Series term: multiply by x^2, divide by a constant, accumulate.
      gsbc_pkg::S_T_MUL: begin
        mul_a     = term_r;
        mul_b     = x2_r;
        state_nxt = gsbc_pkg::S_T_DIV;
      end

      gsbc_pkg::S_T_DIV: begin
        x_nxt     = prod_r[61:30];
        mul_a     = prod_r[61:30];
        mul_b     = gsbc_pkg::RECIP_TAB[step_r];
        state_nxt = gsbc_pkg::S_T_Q;
      end

      gsbc_pkg::S_T_Q: begin
        q0_nxt    = prod_r[63:33];
        state_nxt = gsbc_pkg::S_T_FIX;
      end

      gsbc_pkg::S_T_FIX: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd7) begin
          sin_nxt   = acc_clamp;
          term_nxt  = {1'b0, gsbc_pkg::ONE_Q30};
          acc_nxt   = signed'({3'b000, gsbc_pkg::ONE_Q30});
          state_nxt = gsbc_pkg::S_T_MUL;
        end else if (step_r == 4'd15) begin
          cos_nxt    = acc_clamp;
          branch_nxt = 1'b0;
          state_nxt  = gsbc_pkg::S_SM_A;
        end else begin
          term_nxt  = q_fix;
          acc_nxt   = acc_new;
          state_nxt = gsbc_pkg::S_T_MUL;
        end
      end

      // Sample: radius times trig, times spread, plus mean.
      gsbc_pkg::S_SM_A: begin
        if (!sq_busy) begin
          mul_a     = {1'b0, sq_root};
          mul_b     = {1'b0, trig_mag};
          state_nxt = gsbc_pkg::S_SM_B;
        end
      end

      gsbc_pkg::S_SM_B: begin
        mul_a     = {1'b0, prod_r[60:30]};
        mul_b     = {1'b0, spread_value};
        state_nxt = gsbc_pkg::S_SM_C;
      end

      gsbc_pkg::S_SM_C: begin
        if (branch_r) begin
          second_nxt = sample_sat;
        end else begin
          first_nxt = sample_sat;
        end
        state_nxt = gsbc_pkg::S_SM_D;
      end

      // Tally the sample into the saturating band counters.
      gsbc_pkg::S_SM_D: begin
        band1_nxt = base1;
        band2_nxt = base2;
        band3_nxt = base3;
        if (abs_dist <= sp1 && base1 != '1) begin
          band1_nxt = base1 + 1'b1;
        end
        if (abs_dist <= sp2 && base2 != '1) begin
          band2_nxt = base2 + 1'b1;
        end
        if (abs_dist <= sp3 && base3 != '1) begin
          band3_nxt = base3 + 1'b1;
        end
        if (!branch_r && keep_r) begin
          branch_nxt = 1'b1;
          state_nxt  = gsbc_pkg::S_SM_A;
        end else begin
          state_nxt = gsbc_pkg::S_OUT;
        end
      end

      // Hand the result to the output register once it is free.
      gsbc_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.sample_first       = first_r;
          out_data_nxt.sample_second      = second_r;
          out_data_nxt.second_valid       = keep_r;
          out_data_nxt.within_one_total   = 32'(band1_r);
          out_data_nxt.within_two_total   = 32'(band2_r);
          out_data_nxt.within_three_total = 32'(band3_r);
          state_nxt                       = gsbc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = gsbc_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gsbc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      band1_r     <= '0;
      band2_r     <= '0;
      band3_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      band1_r     <= band1_nxt;
      band2_r     <= band2_nxt;
      band3_r     <= band3_nxt;
    end
  end

  // Datapath registers and the shared multiplier.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    step_r     <= step_nxt;
    branch_r   <= branch_nxt;
    m_r        <= m_nxt;
    lz_r       <= lz_nxt;
    frac_r     <= frac_nxt;
    lnlo_r     <= lnlo_nxt;
    theta_r    <= theta_nxt;
    x2_r       <= x2_nxt;
    term_r     <= term_nxt;
    x_r        <= x_nxt;
    q0_r       <= q0_nxt;
    acc_r      <= acc_nxt;
    sin_r      <= sin_nxt;
    cos_r      <= cos_nxt;
    quad_r     <= quad_nxt;
    afrac_r    <= afrac_nxt;
    keep_r     <= keep_nxt;
    clear_r    <= clear_nxt;
    first_r    <= first_nxt;
    second_r   <= second_nxt;
    out_data_r <= out_data_nxt;
    prod_r     <= mul_a * mul_b;
  end

endmodule

@@ rtl/core/gaussian_sample_band_counter.sv @@
// Top level of the Gaussian sample band counter.
//
// Input channel (in_valid / in_stall / in_data): one transaction carries two
// uniform codes and the keep_second and clear_counts flags. It is taken at a
// clock edge with in_valid high and in_stall low; a two-entry queue sits
// behind the port, so in_stall rises only when that queue is full.
// Result channel (out_valid / out_stall / out_data): one result per input,
// held in an output register until an edge with out_stall low.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
// the mean, index 1 the spread; other indexes are ignored. Write only while
// the block is idle.
// One item is processed at a time; the back end takes the next item from the
// queue only after the last result enters the output register. The log
// squaring, trig series and sample steps all share one 32x32 multiplier.
// Reset (rst_n low, synchronous) empties the queue, clears the band counters
// and the output valid flag, and loads mean 0 and spread 1.0.
// A stalled result holds; the back end then waits with the next result ready.
module gaussian_sample_band_counter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  gsbc_pkg::gsbc_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gsbc_pkg::gsbc_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gsbc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [31:0]                          cfg_data
);

  logic signed [31:0]    mean_r, mean_nxt;
  logic [30:0]           spread_r, spread_nxt;
  logic                  q_full, q_push, q_pop, q_nonempty;
  gsbc_pkg::gsbc_entry_t q_push_data, q_pop_data;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    mean_nxt   = mean_r;
    spread_nxt = spread_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        gsbc_pkg::CFG_MEAN_IDX:   mean_nxt   = cfg_data;
        gsbc_pkg::CFG_SPREAD_IDX: spread_nxt = cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r   <= 32'sd0;
      spread_r <= 31'd65536;
    end else begin
      mean_r   <= mean_nxt;
      spread_r <= spread_nxt;
    end
  end

  gsbc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  gsbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_pop_data)
  );

  gsbc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_nonempty   (q_nonempty),
    .q_data       (q_pop_data),
    .q_pop        (q_pop),
    .mean_value   (mean_r),
    .spread_value (spread_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

@@ rtl/core/gsbc_checker.sv @@
// Port-level checker for the Gaussian sample band counter, bound to the top level.
module gsbc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input gsbc_pkg::gsbc_in_t                in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input gsbc_pkg::gsbc_out_t               out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [gsbc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input logic [31:0]                       cfg_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // The bands nest, so their totals are ordered.
  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.within_one_total <= out_data.within_two_total) &&
                  (out_data.within_two_total <= out_data.within_three_total))
    else $error("band totals out of order");

  // A dropped second sample reads as zero.
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.second_valid |-> out_data.sample_second == 32'sd0)
    else $error("dropped second sample not zero");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gaussian_sample_band_counter gsbc_checker u_gsbc_checker (.*);

@@ tb/gaussian_sample_band_counter_tb.sv @@
// Testbench for the Gaussian sample band counter: random and directed traffic, predicted.
module gaussian_sample_band_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam logic [63:0] LN2X2 = 64'd1488522236;
  localparam logic [63:0] HALFPI = 64'd1686629713;
  localparam logic [63:0] UNIT = 64'd1 << 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gsbc_pkg::gsbc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gsbc_pkg::gsbc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gsbc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gaussian_sample_band_counter dut (.*);

  always #10 clk = ~clk;

  // Predictor state: configuration copy and band counters.
  logic signed [63:0] mdl_mean = 0;
  logic [63:0] mdl_spread = 64'd65536;
  logic [63:0] band_one = 0, band_two = 0, band_three = 0;

  gsbc_pkg::gsbc_in_t pending_items[$];
  gsbc_pkg::gsbc_out_t expected_samples[$];
  int error_count = 0;
  int idle_pct = 36;
  int stall_pct = 36;
  int quiet_cycles = 0;
  bit stim_done = 1'b0;

  // Fixed-point -2 ln(u1) in Q.30.
  function automatic logic [63:0] neg_two_ln(input logic [31:0] code);
    logic [63:0] c, m, frac, t;
    int top;
    c = code & gsbc_pkg::UNIFORM_MASK;
    frac = 0;
    top = 0;
    if (c == 0) c = 1;
    for (int i = 0; i < 64; i++) if (c[i]) top = i;
    m = c << (31 - top);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[29 - i] = 1'b1;
      end
    end
    t = (64'(gsbc_pkg::UNIFORM_BITS - top) << 30) - frac;
    return (t >> 30) * LN2X2 + (((t & (UNIT - 1)) * LN2X2) >> 30);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] v);
    if (v < 0) return 0;
    if (v > $signed(UNIT)) return $signed(UNIT);
    return v;
  endfunction

  // Quadrant-folded Taylor series for cos and sin in Q.30.
  task automatic trig_pair(input logic [31:0] code, output logic signed [63:0] cv,
                           output logic signed [63:0] sv);
    logic [63:0] phase, theta, x2, term;
    logic signed [63:0] s_acc, c_acc, c, s;
    bit neg;
    phase = 64'(code & gsbc_pkg::UNIFORM_MASK) << (32 - gsbc_pkg::UNIFORM_BITS);
    phase = phase & 64'hFFFF_FFFF;
    theta = ((phase & (UNIT - 1)) * HALFPI) >> 30;
    x2 = (theta * theta) >> 30;
    term = theta;
    s_acc = $signed(theta);
    neg = 1'b1;
    for (int k = 3; k <= 17; k += 2) begin
      term = ((term * x2) >> 30) / 64'((k - 1) * k);
      s_acc = neg ? s_acc - $signed(term) : s_acc + $signed(term);
      neg = !neg;
    end
    term = UNIT;
    c_acc = $signed(UNIT);
    neg = 1'b1;
    for (int k = 2; k <= 16; k += 2) begin
      term = ((term * x2) >> 30) / 64'((k - 1) * k);
      c_acc = neg ? c_acc - $signed(term) : c_acc + $signed(term);
      neg = !neg;
    end
    s = clamp_unit(s_acc);
    c = clamp_unit(c_acc);
    case (phase[31:30])
      2'd0: begin cv = c;  sv = s;  end
      2'd1: begin cv = -s; sv = c;  end
      2'd2: begin cv = -c; sv = -s; end
      default: begin cv = s; sv = -c; end
    endcase
  endtask

  function automatic logic signed [63:0] scale_sample(input logic [63:0] radius,
                                                      input logic signed [63:0] trig);
    logic [63:0] mag;
    logic signed [63:0] v;
    mag = (radius * 64'(trig < 0 ? -trig : trig)) >> 30;
    mag = (mag * mdl_spread) >> 28;
    v = (trig < 0) ? mdl_mean - $signed(mag) : mdl_mean + $signed(mag);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] bump(input logic [63:0] cnt);
    logic [63:0] cap;
    cap = (64'd1 << gsbc_pkg::COUNT_BITS) - 1;
    return (cnt >= cap) ? cap : cnt + 1;
  endfunction

  task automatic tally_band(input logic signed [63:0] smp);
    logic signed [63:0] d, sp;
    d = smp - mdl_mean;
    sp = $signed(mdl_spread);
    if (d < 0) d = -d;
    if (d <= sp) band_one = bump(band_one);
    if (d <= 2 * sp) band_two = bump(band_two);
    if (d <= 3 * sp) band_three = bump(band_three);
  endtask

  // Work out the result for one accepted transaction and queue it.
  task automatic predict_samples(input gsbc_pkg::gsbc_in_t it);
    logic [63:0] radius;
    logic signed [63:0] cv, sv, first, second;
    gsbc_pkg::gsbc_out_t r;
    radius = int_sqrt(neg_two_ln(it.uniform_radius) << 26);
    trig_pair(it.uniform_angle, cv, sv);
    if (it.clear_counts) begin
      band_one = 0;
      band_two = 0;
      band_three = 0;
    end
    first = scale_sample(radius, cv);
    tally_band(first);
    second = 0;
    if (it.keep_second) begin
      second = scale_sample(radius, sv);
      tally_band(second);
    end
    r.sample_first = first[31:0];
    r.sample_second = second[31:0];
    r.second_valid = it.keep_second;
    r.within_one_total = band_one[31:0];
    r.within_two_total = band_two[31:0];
    r.within_three_total = band_three[31:0];
    expected_samples.push_back(r);
  endtask

  // Driver: presents queued transactions with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_samples(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_data);
          error_count++;
        end else begin
          gsbc_pkg::gsbc_out_t e;
          e = expected_samples.pop_front();
          if (out_data !== e) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, e, out_data);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || stim_done)
      quiet_cycles <= 0;
    else if (pending_items.size() > 0 || expected_samples.size() > 0 || in_valid) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One register write; the closing clock wait keeps back-to-back writes apart.
  task automatic write_reg(input gsbc_pkg::gsbc_cfg_idx_t idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == gsbc_pkg::CFG_MEAN_IDX) mdl_mean = $signed({{32{val[31]}}, val});
    else if (idx == gsbc_pkg::CFG_SPREAD_IDX) mdl_spread = 64'(val[30:0]);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic gsbc_pkg::gsbc_in_t rand_item();
    gsbc_pkg::gsbc_in_t it;
    it.uniform_radius = $urandom();
    if ($urandom_range(9) == 0) it.uniform_radius = $urandom_range(3);
    else if ($urandom_range(9) == 0) it.uniform_radius = 32'hFFFF_FFFF - $urandom_range(3);
    else if ($urandom_range(9) == 0) it.uniform_radius = $urandom() >> $urandom_range(31);
    it.uniform_angle = $urandom();
    if ($urandom_range(7) == 0) it.uniform_angle = {2'($urandom_range(3)), 30'h0};
    it.keep_second = 1'($urandom_range(1));
    it.clear_counts = ($urandom_range(19) == 0);
    return it;
  endfunction

  task automatic random_phase(input int n);
    repeat (n) pending_items.push_back(rand_item());
    wait_drained();
  endtask

  initial begin
    gsbc_pkg::gsbc_in_t it;
    logic [31:0] dir_radius[6];
    logic [31:0] dir_angle[6];
    dir_radius = '{32'd0, 32'd1, 32'd2, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000};
    dir_angle = '{32'd0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                  32'hFFFF_FFFF, 32'h3FFF_FFFF};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme codes, every quadrant, both flags.
    for (int i = 0; i < 6; i++) begin
      it.uniform_radius = dir_radius[i];
      it.uniform_angle = dir_angle[i];
      it.keep_second = i[0];
      it.clear_counts = (i == 3);
      pending_items.push_back(it);
    end
    for (int i = 0; i < 6; i++) begin
      it.uniform_radius = dir_radius[5 - i];
      it.uniform_angle = dir_angle[i];
      it.keep_second = !i[0];
      it.clear_counts = 1'b0;
      pending_items.push_back(it);
    end
    wait_drained();

    // Zero spread, then extreme mean with large spread to force saturation.
    write_reg(gsbc_pkg::CFG_SPREAD_IDX, 32'd0);
    write_reg(gsbc_pkg::CFG_MEAN_IDX, 32'h7FFF_FFFF);
    random_phase(8);
    write_reg(gsbc_pkg::CFG_SPREAD_IDX, 32'h7FFF_FFFF);
    random_phase(8);
    write_reg(gsbc_pkg::CFG_MEAN_IDX, 32'h8000_0000);
    write_reg(gsbc_pkg::CFG_SPREAD_IDX, 32'hFFFF_FFFF);
    random_phase(8);

    // No idling stretch, then back to random pressure over several settings.
    idle_pct = 0;
    stall_pct = 0;
    write_reg(gsbc_pkg::CFG_MEAN_IDX, 32'h0000_0000);
    write_reg(gsbc_pkg::CFG_SPREAD_IDX, 32'h0001_0000);
    random_phase(150);
    idle_pct = 36;
    stall_pct = 36;
    for (int p = 0; p < 6; p++) begin
      write_reg(gsbc_pkg::CFG_MEAN_IDX, $urandom());
      write_reg(gsbc_pkg::CFG_SPREAD_IDX, $urandom() >> $urandom_range(16));
      if ($urandom_range(3) == 0) write_reg(gsbc_pkg::gsbc_cfg_idx_t'(2'd3), $urandom());
      random_phase(125);
    end

    stim_done = 1'b1;
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
